// ----- sv/lottery_scheduler_pick_unit_assert.svh -----
// assertion macros for the lottery scheduler pick unit
// included by the top level; no other dependencies
`ifndef LOTTERY_SCHEDULER_PICK_UNIT_ASSERT_SVH
`define LOTTERY_SCHEDULER_PICK_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define LSP_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lottery pick unit: assertion failed");
`define LSP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lottery pick unit: assertion failed");
`else
`define LSP_ASSERT_IMP(label, clk, rst, pre, post)
`define LSP_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ----- sv/lsp_pkg.sv -----
// shared constants and controller/datapath command and status types
// for the lottery scheduler pick unit; no dependencies
package lsp_pkg;
   localparam int NUM_SLOTS_DEF = 8;
   localparam int TICKET_W      = 8;
   localparam int TOTAL_W       = 11;
   localparam int RND_W         = 32;
   localparam int CNT_W         = 5;
   localparam int CSR_IDX_W     = 3;
   localparam int MASK_W        = 8;
   localparam int SLOT_FIELD_W  = 3;
   localparam int REQ_W         = 48;
   localparam int RSP_W         = 32;
   localparam logic [TICKET_W-1:0] TICKET_RESET = 8'd1;

   typedef struct packed {
      logic load;
      logic sum_en;
      logic div_en;
      logic scan_en;
      logic out_load;
      logic cnt_clr;
   } lsp_cmd_type;

   typedef struct packed {
      logic slot_last;
      logic bit_last;
      logic total_zero;
   } lsp_status_type;
endpackage

// ----- sv/lsp_ctrl.sv -----
// sequencer for the lottery pick: sum, remainder, scan, result handoff
// depends on lsp_pkg
module lsp_ctrl import lsp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  lsp_status_type status,
   output lsp_cmd_type    cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_SUM, S_CHK, S_DIV, S_SCAN, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.cnt_clr = 1'b1;
            cmd.load    = req_tvalid;
            if (req_tvalid) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            cmd.sum_en = 1'b1;
            if (status.slot_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_CHK;
            end
         end
         S_CHK: begin
            cmd.cnt_clr = 1'b1;
            state_in    = status.total_zero ? S_DONE : S_DIV;
         end
         S_DIV: begin
            cmd.div_en = 1'b1;
            if (status.bit_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_en = 1'b1;
            if (status.slot_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            cmd.out_load = !rsp_valid_ff || rsp_tready;
            if (cmd.out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
endmodule

// ----- sv/lsp_dp.sv -----
// datapath of the lottery pick: ticket registers, total accumulator,
// bit-serial remainder and slot scan; depends on lsp_pkg
module lsp_dp import lsp_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lsp_cmd_type             cmd,
   output lsp_status_type          status,
   input  logic                    csr_wr,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [TICKET_W-1:0]     csr_data,
   input  logic [MASK_W-1:0]       req_mask,
   input  logic                    req_running,
   input  logic [RND_W-1:0]        req_random,
   output logic [SLOT_FIELD_W-1:0] next_slot,
   output logic [TOTAL_W-1:0]      ticket_total,
   output logic [TOTAL_W-1:0]      winning_ticket,
   output logic                    none_ready
);
   localparam int SLOT_W = $clog2(NUM_SLOTS);

   logic [TICKET_W-1:0]     tickets_ff [NUM_SLOTS];
   logic [SLOT_W-1:0]       cur_ff, cur_in;
   logic [NUM_SLOTS-1:0]    ready_ff, ready_in;
   logic [RND_W-1:0]        rnd_ff, rnd_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic [TOTAL_W-1:0]      rem_ff, rem_in;
   logic [TOTAL_W-1:0]      acc_ff, acc_in;
   logic                    found_ff, found_in;
   logic [SLOT_W-1:0]       pick_ff, pick_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SLOT_FIELD_W-1:0] next_slot_ff;
   logic [TOTAL_W-1:0]      total_out_ff, win_out_ff;
   logic                    none_ff;

   logic [SLOT_W-1:0]       idx;
   logic [TICKET_W-1:0]     tick_rd;
   logic [TOTAL_W:0]        trial, diff;
   logic [TOTAL_W-1:0]      acc_sum;
   logic [SLOT_W-1:0]       pick_slot;

   assign idx       = cnt_ff[SLOT_W-1:0];
   assign tick_rd   = tickets_ff[idx];
   assign trial     = {rem_ff, rnd_ff[RND_W-1]};
   assign diff      = trial - {1'b0, total_ff};
   assign acc_sum   = acc_ff + TOTAL_W'(tick_rd);
   assign pick_slot = found_ff ? pick_ff : cur_ff;

   always_comb begin
      ready_in = ready_ff;
      rnd_in   = rnd_ff;
      total_in = total_ff;
      rem_in   = rem_ff;
      acc_in   = acc_ff;
      found_in = found_ff;
      pick_in  = pick_ff;
      cur_in   = cur_ff;
      cnt_in   = cmd.cnt_clr ? '0 : cnt_ff + CNT_W'(1);
      if (cmd.load) begin
         ready_in = req_mask[NUM_SLOTS-1:0]
                  | (req_running ? (NUM_SLOTS'(1) << cur_ff) : '0);
         rnd_in   = req_random;
         total_in = '0;
         rem_in   = '0;
         acc_in   = '0;
         found_in = 1'b0;
      end
      if (cmd.sum_en && ready_ff[idx]) begin
         total_in = total_ff + TOTAL_W'(tick_rd);
      end
      if (cmd.div_en) begin
         rem_in = (trial >= {1'b0, total_ff}) ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
         rnd_in = {rnd_ff[RND_W-2:0], 1'b0};
      end
      if (cmd.scan_en && ready_ff[idx] && !found_ff) begin
         acc_in = acc_sum;
         if (rem_ff < acc_sum) begin
            found_in = 1'b1;
            pick_in  = idx;
         end
      end
      if (cmd.out_load) begin
         cur_in = pick_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            tickets_ff[i] <= TICKET_RESET;
         end
         cur_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (csr_wr && (32'(csr_index) < NUM_SLOTS)) begin
            tickets_ff[csr_index[SLOT_W-1:0]] <= csr_data;
         end
         cur_ff <= cur_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ready_ff <= ready_in;
      rnd_ff   <= rnd_in;
      total_ff <= total_in;
      rem_ff   <= rem_in;
      acc_ff   <= acc_in;
      found_ff <= found_in;
      pick_ff  <= pick_in;
      if (cmd.out_load) begin
         next_slot_ff <= SLOT_FIELD_W'(pick_slot);
         total_out_ff <= total_ff;
         win_out_ff   <= rem_ff;
         none_ff      <= (total_ff == '0);
      end
   end

   assign status.slot_last  = (cnt_ff == CNT_W'(NUM_SLOTS - 1));
   assign status.bit_last   = (cnt_ff == CNT_W'(RND_W - 1));
   assign status.total_zero = (total_ff == '0);

   assign next_slot      = next_slot_ff;
   assign ticket_total   = total_out_ff;
   assign winning_ticket = win_out_ff;
   assign none_ready     = none_ff;
endmodule

// ----- sv/lottery_scheduler_pick_unit.sv -----
// Lottery pick unit: one reschedule request in, one pick out. The ticket sum
// and the slot scan handle one slot per cycle each, and the remainder unit
// retires one bit of the random word per cycle; when the ready tickets total
// zero, the remainder and the scan are skipped. A finished pick waits in the
// output register while the next request is taken.
// Ticket registers may be written at any time the unit is idle; csr_ready is
// always high. No clearing pass is needed after reset.
// depends on lsp_pkg, lsp_ctrl, lsp_dp and lottery_scheduler_pick_unit_assert.svh
`include "lottery_scheduler_pick_unit_assert.svh"
module lottery_scheduler_pick_unit import lsp_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // ready_mask[7:0], current_running[8], random_word[40:9], zero fill
   input  logic [REQ_W-1:0]     req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // next_slot[2:0], ticket_total[13:3], winning_ticket[24:14], none_ready[25]
   output logic [RSP_W-1:0]     rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICKET_W-1:0]  csr_data
);
   lsp_cmd_type             cmd;
   lsp_status_type          status;
   logic [SLOT_FIELD_W-1:0] next_slot;
   logic [TOTAL_W-1:0]      ticket_total;
   logic [TOTAL_W-1:0]      winning_ticket;
   logic                    none_ready;

   assign csr_ready = 1'b1;

   lsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lsp_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_wr         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_mask       (req_tdata[MASK_W-1:0]),
      .req_running    (req_tdata[MASK_W]),
      .req_random     (req_tdata[MASK_W+RND_W:MASK_W+1]),
      .next_slot      (next_slot),
      .ticket_total   (ticket_total),
      .winning_ticket (winning_ticket),
      .none_ready     (none_ready)
   );

   assign rsp_tdata = RSP_W'({none_ready, winning_ticket, ticket_total, next_slot});

   `LSP_ASSERT_IMP(a_win_below_total, clock, reset, rsp_tvalid && !none_ready, winning_ticket < ticket_total)
   `LSP_ASSERT_IMP(a_empty_lottery, clock, reset, rsp_tvalid && none_ready, ticket_total == '0 && winning_ticket == '0)
   `LSP_ASSERT_IMP(a_slot_in_range, clock, reset, rsp_tvalid, 32'(next_slot) < NUM_SLOTS)
   `LSP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
endmodule

// ----- bench/testbench.sv -----
// testbench for lottery_scheduler_pick_unit: directed and random reschedule requests,
// each pick predicted from a local copy of ticket counts and current slot
// depends on lsp_pkg and the lottery_scheduler_pick_unit rtl
`timescale 1ns / 100ps
module testbench import lsp_pkg::*;;

   localparam int LIMIT_CYCLES = 500000;
   localparam int HOLD_CYCLES  = 600;
   localparam int MAX_PRINTS   = 60;

   typedef struct packed {
      logic [2:0]  slot;
      logic [10:0] total;
      logic [10:0] winner;
      logic        none;
   } pick_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TICKET_W-1:0]  csr_data = '0;

   logic [7:0] ticket_table [8];
   logic [2:0] running_slot;
   pick_type   expected_picks [$];
   int         mismatch_count = 0;
   int         cycle_count = 0;
   int         picks_checked = 0;
   int         empty_draws = 0;
   int         ticket_settings = 0;
   int         sink_hold = 0;
   bit         sink_gaps = 1'b0;
   bit         source_gaps = 1'b0;

   always #4 clock = ~clock;

   lottery_scheduler_pick_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   function automatic pick_type predict_pick(input logic [7:0] mask, input logic run,
                                             input logic [31:0] rnd);
      logic [7:0]  pool;
      logic [10:0] sum;
      logic [10:0] acc;
      logic [31:0] win;
      bit          found;
      pick_type    p;
      int          i;
      pool = mask;
      if (run) begin
         pool[running_slot] = 1'b1;
      end
      sum = '0;
      for (i = 0; i < 8; i++) begin
         if (pool[i]) begin
            sum = sum + 11'(ticket_table[i]);
         end
      end
      p.total = sum;
      p.none = (sum == '0);
      p.winner = '0;
      if (sum != '0) begin
         win = rnd % {21'd0, sum};
         p.winner = win[10:0];
         acc = '0;
         found = 1'b0;
         for (i = 0; i < 8; i++) begin
            if (pool[i] && !found) begin
               acc = acc + 11'(ticket_table[i]);
               if (win < {21'd0, acc}) begin
                  running_slot = i[2:0];
                  found = 1'b1;
               end
            end
         end
      end
      p.slot = running_slot;
      return p;
   endfunction

   task automatic report_mismatch(input string what, input int got_val, input int want_val);
      if (mismatch_count < MAX_PRINTS) begin
         $display("[%0t] %s: got %0d, want %0d", $realtime, what, got_val, want_val);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // result sink: long hold when asked, otherwise random stalls when gaps are enabled
   always @(posedge clock) begin
      if (sink_hold > 0) begin
         sink_hold <= sink_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(sink_gaps && $urandom_range(99) < 27);
      end
   end

   // predicts on each accepted request, checks each accepted pick
   always @(posedge clock) begin
      pick_type want;
      pick_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_picks.push_back(predict_pick(req_tdata[7:0], req_tdata[8],
                                                  req_tdata[40:9]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.slot = rsp_tdata[2:0];
            got.total = rsp_tdata[13:3];
            got.winner = rsp_tdata[24:14];
            got.none = rsp_tdata[25];
            if (expected_picks.size() == 0) begin
               report_mismatch("pick with no request pending", int'(got.slot), -1);
            end else begin
               want = expected_picks.pop_front();
               picks_checked++;
               if (want.none) begin
                  empty_draws++;
               end
               if (got.slot !== want.slot) begin
                  report_mismatch("next_slot", int'(got.slot), int'(want.slot));
               end
               if (got.total !== want.total) begin
                  report_mismatch("ticket_total", int'(got.total), int'(want.total));
               end
               if (got.winner !== want.winner) begin
                  report_mismatch("winning_ticket", int'(got.winner), int'(want.winner));
               end
               if (got.none !== want.none) begin
                  report_mismatch("none_ready", int'(got.none), int'(want.none));
               end
            end
         end
      end
   end

   task automatic send_request(input logic [7:0] mask, input logic run, input logic [31:0] rnd);
      while (source_gaps && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, rnd, run, mask};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_picks;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_picks.size() != 0) @(posedge clock);
   endtask

   // slot i takes bits [8*i +: 8]
   task automatic program_tickets(input logic [63:0] counts);
      int i;
      for (i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= i[2:0];
         csr_data <= counts[8*i +: 8];
         do @(posedge clock); while (!csr_ready);
         ticket_table[i] = counts[8*i +: 8];
      end
      csr_valid <= 1'b0;
      ticket_settings++;
   endtask

   task automatic test_reset_tickets;
      send_request(8'h00, 1'b0, 32'h1234_5678);
      send_request(8'h00, 1'b1, 32'd5);
      send_request(8'hFF, 1'b0, 32'hFFFF_FFFF);
      send_request(8'h00, 1'b1, 32'd0);
      send_request(8'h01, 1'b0, 32'd0);
      send_request(8'h80, 1'b1, 32'd3);
      drain_picks();
   endtask

   task automatic test_ticket_extremes;
      program_tickets({8{8'hFF}});
      send_request(8'hFF, 1'b0, 32'hFFFF_FFFF);
      send_request(8'hFF, 1'b1, 32'd2039);
      send_request(8'hFF, 1'b0, 32'd0);
      send_request(8'hAA, 1'b0, 32'h8000_0000);
      send_request(8'h55, 1'b1, 32'd255);
      drain_picks();
      program_tickets(64'd0);
      send_request(8'hFF, 1'b1, 32'hFFFF_FFFF);
      send_request(8'h00, 1'b1, 32'd0);
      drain_picks();
      // zero-ticket slot 0 ready alongside a heavy and a light slot
      program_tickets(64'h0100_0000_0000_FF00);
      send_request(8'h01, 1'b0, 32'd77);
      send_request(8'h03, 1'b0, 32'd12345);
      send_request(8'h81, 1'b0, 32'd255);
      send_request(8'h01, 1'b1, 32'hDEAD_BEEF);
      drain_picks();
   endtask

   task automatic test_random_lottery(input int count, input bit gaps);
      logic [63:0] counts;
      logic [7:0]  mask;
      logic [31:0] rnd;
      int          i;
      for (i = 0; i < 8; i++) begin
         case ($urandom_range(3))
            0: counts[8*i +: 8] = 8'd0;
            1: counts[8*i +: 8] = 8'hFF;
            default: counts[8*i +: 8] = 8'($urandom_range(255));
         endcase
      end
      program_tickets(counts);
      source_gaps = gaps;
      sink_gaps <= gaps;
      for (i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0: mask = 8'h00;
            1: mask = 8'h01 << $urandom_range(7);
            2: mask = 8'hFF;
            default: mask = 8'($urandom_range(255));
         endcase
         case ($urandom_range(5))
            0: rnd = $urandom_range(4095);
            1: rnd = 32'hFFFF_FFFF - $urandom_range(4095);
            default: rnd = $urandom;
         endcase
         send_request(mask, 1'($urandom_range(1)), rnd);
      end
      drain_picks();
   endtask

   task automatic test_backpressure;
      int i;
      source_gaps = 1'b0;
      sink_hold <= HOLD_CYCLES;
      for (i = 0; i < 24; i++) begin
         send_request(8'($urandom_range(255)), 1'($urandom_range(1)), $urandom);
      end
      drain_picks();
   endtask

   initial begin
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int i;
      for (i = 0; i < 8; i++) begin
         ticket_table[i] = TICKET_RESET;
      end
      running_slot = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      sink_gaps <= 1'b1;
      @(posedge clock);
      test_reset_tickets();
      test_ticket_extremes();
      for (i = 0; i < 5; i++) begin
         test_random_lottery(110, 1'b1);
      end
      test_random_lottery(110, 1'b0);
      test_backpressure();
      repeat (60) @(posedge clock);
      while (expected_picks.size() != 0) begin
         report_mismatch("pick never delivered", 0, int'(expected_picks[0].slot));
         void'(expected_picks.pop_front());
      end
      $display("checked %0d picks across %0d ticket settings", picks_checked, ticket_settings);
      $display("%0d draws found no ready tickets", empty_draws);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
